### src/vrt_pkg.sv
`default_nettype none

package vrt_pkg;

  localparam int MODEL_W     = 16;
  localparam int WORLD_W     = 24;
  localparam int ANGLE_W     = 16;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int TRIG_W      = 17;

  typedef logic signed [MODEL_W-1:0] model_coord_t;
  typedef logic signed [WORLD_W-1:0] world_coord_t;
  typedef logic        [ANGLE_W-1:0] angle_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic        [CFG_INDEX_W-1:0] cfg_index_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROTATION_ANGLE = 2'd0,
    REG_OFFSET_X       = 2'd1,
    REG_OFFSET_Y       = 2'd2
  } reg_index_t;

  // Q1.15 sine and cosine of the current rotation
  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_val;
    logic signed [TRIG_W-1:0] cos_val;
  } trig_t;

endpackage

`default_nettype wire

### src/vrt_model_if.sv
`default_nettype none

interface vrt_model_if;
  import vrt_pkg::*;

  logic         valid;
  logic         ready;
  model_coord_t model_x;
  model_coord_t model_y;

  modport source (output valid, output model_x, output model_y, input ready);
  modport sink   (input valid, input model_x, input model_y, output ready);
endinterface

`default_nettype wire

### src/vrt_world_if.sv
`default_nettype none

interface vrt_world_if;
  import vrt_pkg::*;

  logic         valid;
  logic         ready;
  world_coord_t world_x;
  world_coord_t world_y;

  modport source (output valid, output world_x, output world_y, input ready);
  modport sink   (input valid, input world_x, input world_y, output ready);
endinterface

`default_nettype wire

### src/vrt_cfg_if.sv
`default_nettype none

interface vrt_cfg_if;
  import vrt_pkg::*;

  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/vertex_rotate_translate.sv
// Places one model-space vertex (signed Q8.8) in world space (signed Q16.8, saturated) using
// the rotation and translation held in three configuration registers. The datapath is a
// three-stage pipeline (input register, product register, result register) and accepts
// one vertex in every clock cycle while the output side is not stalled; a vertex passes from
// the input register through the product register to the result register. While a finished
// result waits, the result register holds it and the two stages in front of it still take new
// vertices until they are full, so a stall fills those stages before the input side is held.
// Sine and cosine come from a quarter-wave constant table of SINE_TABLE_ENTRIES+1 entries and
// are registered behind the angle register; a rotation write applies to the next vertex accepted after it.
`default_nettype none

module vertex_rotate_translate #(
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  wire           clk,
  input  wire           rst,
  vrt_cfg_if.sink       cfg,
  vrt_model_if.sink     model,
  vrt_world_if.source   world
);
  import vrt_pkg::*;

  localparam int PROD_W = MODEL_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_SHIFT = 15;
  localparam int RND_W  = SUM_W - RND_SHIFT;
  localparam int TOT_W  = WORLD_W + 1;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1 << (RND_SHIFT - 1));
  localparam logic signed [TOT_W-1:0] OUT_MAX = TOT_W'((1 << (WORLD_W - 1)) - 1);
  localparam logic signed [TOT_W-1:0] OUT_MIN = -TOT_W'(1 << (WORLD_W - 1));

  angle_t       rotation_angle;
  world_coord_t offset_x;
  world_coord_t offset_y;
  trig_t        trig_now;
  trig_t        trig_q;

  logic         v1;
  model_coord_t mx1;
  model_coord_t my1;

  logic                     v2;
  logic signed [PROD_W-1:0] p_xc;
  logic signed [PROD_W-1:0] p_ys;
  logic signed [PROD_W-1:0] p_xs;
  logic signed [PROD_W-1:0] p_yc;

  logic         v3;
  world_coord_t wx3;
  world_coord_t wy3;

  logic en1;
  logic en2;
  logic en3;

  logic signed [SUM_W-1:0] rx;
  logic signed [SUM_W-1:0] ry;
  world_coord_t            wx_next;
  world_coord_t            wy_next;

  vrt_trig #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_trig (
    .angle (rotation_angle),
    .trig  (trig_now)
  );

  function automatic world_coord_t place(logic signed [SUM_W-1:0] rot,
                                         world_coord_t off);
    logic signed [SUM_W-1:0] rnd;
    logic signed [TOT_W-1:0] tot;
    rnd = (rot + RND_HALF) >>> RND_SHIFT;
    tot = TOT_W'(signed'(rnd[RND_W-1:0])) + TOT_W'(off);
    if (tot > OUT_MAX) begin
      return OUT_MAX[WORLD_W-1:0];
    end else if (tot < OUT_MIN) begin
      return OUT_MIN[WORLD_W-1:0];
    end
    return tot[WORLD_W-1:0];
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_angle <= '0;
      offset_x       <= '0;
      offset_y       <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ROTATION_ANGLE: rotation_angle <= cfg.data[ANGLE_W-1:0];
        REG_OFFSET_X:       offset_x       <= world_coord_t'(cfg.data);
        REG_OFFSET_Y:       offset_y       <= world_coord_t'(cfg.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    trig_q <= trig_now;
  end

  assign en3 = !v3 || world.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign model.ready = en1;

  assign rx = SUM_W'(p_xc) - SUM_W'(p_ys);
  assign ry = SUM_W'(p_xs) + SUM_W'(p_yc);
  assign wx_next = place(rx, offset_x);
  assign wy_next = place(ry, offset_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= model.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      mx1 <= model.model_x;
      my1 <= model.model_y;
    end
    if (en2) begin
      p_xc <= mx1 * trig_q.cos_val;
      p_ys <= my1 * trig_q.sin_val;
      p_xs <= mx1 * trig_q.sin_val;
      p_yc <= my1 * trig_q.cos_val;
    end
    if (en3) begin
      wx3 <= wx_next;
      wy3 <= wy_next;
    end
  end

  assign world.valid   = v3;
  assign world.world_x = wx3;
  assign world.world_y = wy3;

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (model.valid && model.ready) |=> v1)
    else $error("accepted item missing from input stage");

  a_full_holds_input: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && !world.ready) |-> !model.ready)
    else $error("input accepted while pipeline full and stalled");

  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    (v2 && (!v3 || world.ready)) |=> v3)
    else $error("product stage item lost on advance");

  a_angle_write: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready && cfg.index == REG_ROTATION_ANGLE)
      |=> rotation_angle == $past(cfg.data[ANGLE_W-1:0]))
    else $error("rotation write not taken");

endmodule

`default_nettype wire

### src/vrt_trig.sv
`default_nettype none

module vrt_trig #(
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  vrt_pkg::angle_t angle,
  output vrt_pkg::trig_t  trig
);
  import vrt_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int QUAD_SHIFT = ANGLE_W - 2;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q15 = 64'd32768;
  localparam logic [63:0] TAYLOR_DIV [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef logic [15:0] sine_table_t [0:SINE_TABLE_ENTRIES];

  function automatic logic [15:0] sine_entry(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 64'd16384) >> 15;
    if (r > ONE_Q15) begin
      r = ONE_Q15;
    end
    return r[15:0];
  endfunction

  function automatic sine_table_t build_table();
    sine_table_t t;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam sine_table_t SINE_TABLE = build_table();

  function automatic logic signed [TRIG_W-1:0] lookup(angle_t a);
    logic [1:0]                quad;
    logic [QUAD_SHIFT-1:0]     frac;
    logic [QUAD_SHIFT+IDX_W-1:0] scaled;
    logic [IDX_W-1:0]          idx;
    logic [15:0]               mag;
    logic signed [TRIG_W-1:0]  val;
    quad   = a[ANGLE_W-1 -: 2];
    frac   = a[QUAD_SHIFT-1:0];
    scaled = (QUAD_SHIFT+IDX_W)'(frac) * (QUAD_SHIFT+IDX_W)'(SINE_TABLE_ENTRIES);
    idx    = scaled[QUAD_SHIFT +: IDX_W];
    if (quad[0]) begin
      mag = SINE_TABLE[IDX_W'(SINE_TABLE_ENTRIES) - idx];
    end else begin
      mag = SINE_TABLE[idx];
    end
    val = signed'({1'b0, mag});
    return quad[1] ? -val : val;
  endfunction

  assign trig.sin_val = lookup(angle);
  assign trig.cos_val = lookup(angle + angle_t'(1 << QUAD_SHIFT));

endmodule

`default_nettype wire

### bench/vrt_placement_check.sv
`default_nettype none

module vrt_placement_check #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire   clk,
  input  wire   rst,
  vrt_cfg_if    cfg,
  vrt_model_if  model,
  vrt_world_if  world,
  output int    fail_count,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vrt_pkg::*;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q15     = 64'd32768;
  localparam longint          WORLD_MAX   = 64'sd8388607;
  localparam longint          WORLD_MIN   = -64'sd8388608;

  typedef struct {
    world_coord_t wx;
    world_coord_t wy;
  } world_item_t;

  longint unsigned sine_rom [0:TABLE_ENTRIES];

  angle_t       angle;
  world_coord_t off_x;
  world_coord_t off_y;
  world_item_t  world_due [$];
  world_item_t  due;

  function automatic longint unsigned sine_q15_entry(int k);
    longint unsigned x, x2, term, sum, r;
    x = HALF_PI_Q30 * 64'(k) / 64'(TABLE_ENTRIES);
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 64'd16384) >> 15;
    if (r > ONE_Q15) begin
      r = ONE_Q15;
    end
    return r;
  endfunction

  initial begin
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      sine_rom[k] = sine_q15_entry(k);
    end
  end

  function automatic longint trig_q15(angle_t a);
    int     idx;
    longint mag;
    idx = (int'(a[13:0]) * TABLE_ENTRIES) >> 14;
    if (idx > TABLE_ENTRIES) begin
      idx = TABLE_ENTRIES;
    end
    mag = a[14] ? longint'(sine_rom[TABLE_ENTRIES - idx]) : longint'(sine_rom[idx]);
    return a[15] ? -mag : mag;
  endfunction

  function automatic world_coord_t settle(longint rotated, world_coord_t off);
    longint v, o;
    o = off;
    v = ((rotated + 64'sd16384) >>> 15) + o;
    if (v > WORLD_MAX) begin
      v = WORLD_MAX;
    end
    if (v < WORLD_MIN) begin
      v = WORLD_MIN;
    end
    return v[WORLD_W-1:0];
  endfunction

  function automatic world_item_t place_vertex(model_coord_t mx, model_coord_t my);
    longint      s, c, x, y;
    angle_t      quarter_on;
    world_item_t w;
    x = mx;
    y = my;
    quarter_on = angle + 16'h4000;
    s = trig_q15(angle);
    c = trig_q15(quarter_on);
    w.wx = settle(x * c - y * s, off_x);
    w.wy = settle(x * s + y * c, off_y);
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      angle = '0;
      off_x = '0;
      off_y = '0;
      world_due.delete();
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ROTATION_ANGLE: angle = cfg.data[ANGLE_W-1:0];
          REG_OFFSET_X:       off_x = cfg.data;
          REG_OFFSET_Y:       off_y = cfg.data;
          default: ;
        endcase
      end
      if (model.valid && model.ready) begin
        world_due.push_back(place_vertex(model.model_x, model.model_y));
      end
      if (world.valid && world.ready) begin
        if (world_due.size() == 0) begin
          $display("%0t: unexpected item world_x %0d world_y %0d",
                   $time, world.world_x, world.world_y);
          fail_count++;
        end else begin
          due = world_due.pop_front();
          if (world.world_x !== due.wx) begin
            $display("%0t: world_x expected %0d, got %0d", $time, due.wx, world.world_x);
            fail_count++;
          end
          if (world.world_y !== due.wy) begin
            $display("%0t: world_y expected %0d, got %0d", $time, due.wy, world.world_y);
            fail_count++;
          end
        end
      end
    end
    pending = world_due.size();
  end

endmodule

`default_nettype wire

### bench/tb_vertex_rotate_translate.sv
`default_nettype none

module tb_vertex_rotate_translate;
  timeunit 1ns;
  timeprecision 1ps;
  import vrt_pkg::*;

  localparam int         TABLE_ENTRIES = 256;
  localparam int         RANDOM_ITEMS  = 950;
  localparam int         LONG_HOLD     = 80;
  localparam int         QUIET_LIMIT   = 1000;
  localparam int         SETTLE_CYCLES = 10;
  localparam cfg_index_t REG_SPARE     = 2'd3;

  logic clk;
  logic rst;
  bit   steady;
  int   fail_count;
  int   pending;
  int   results_taken;
  int   quiet_cycles;
  int   sent;

  vrt_cfg_if   cfg_ch ();
  vrt_model_if model_ch ();
  vrt_world_if world_ch ();

  vertex_rotate_translate #(
    .SINE_TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .model(model_ch),
    .world(world_ch)
  );

  vrt_placement_check #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_placement_check (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_ch),
    .model     (model_ch),
    .world     (world_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (model_ch.valid && model_ch.ready)
        || (world_ch.valid && world_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, with a long hold now and then to back up the pipe
  initial begin
    int stall;
    world_ch.ready = 1'b0;
    results_taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (results_taken % 300 == 150) begin
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        world_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      world_ch.ready = 1'b1;
      @(posedge clk);
      while (!world_ch.valid) @(posedge clk);
      results_taken++;
      @(negedge clk);
    end
  end

  task automatic write_reg(cfg_index_t idx, cfg_data_t value);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // angle goes out with random junk above bit 15
  task automatic set_pose(angle_t a, world_coord_t ox, world_coord_t oy);
    cfg_data_t value;
    value = cfg_data_t'($urandom);
    value[ANGLE_W-1:0] = a;
    write_reg(REG_ROTATION_ANGLE, value);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic poke_spare();
    write_reg(REG_SPARE, cfg_data_t'($urandom));
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_vertex(model_coord_t x, model_coord_t y);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      model_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    model_ch.model_x = x;
    model_ch.model_y = y;
    model_ch.valid   = 1'b1;
    @(posedge clk);
    while (!model_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    model_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_corners();
    send_vertex(16'sh0000, 16'sh0000);
    send_vertex(16'sh7FFF, 16'sh7FFF);
    send_vertex(16'sh8000, 16'sh8000);
    send_vertex(16'sh7FFF, 16'sh8000);
    send_vertex(16'sh8000, 16'sh7FFF);
    send_vertex(16'sh0001, 16'shFFFF);
    drain();
  endtask

  function automatic model_coord_t pick_coord();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return model_coord_t'($urandom);
    endcase
  endfunction

  function automatic angle_t pick_angle();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'h4000;
      2:       return 16'h8000;
      3:       return 16'hC000;
      4:       return 16'hFFFF;
      default: return angle_t'($urandom);
    endcase
  endfunction

  function automatic world_coord_t pick_offset();
    case ($urandom_range(0, 7))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return 24'sh000000;
      3:       return world_coord_t'($urandom_range(0, 2047)) - 24'sd1024;
      default: return world_coord_t'($urandom);
    endcase
  endfunction

  initial begin
    rst              = 1'b1;
    steady           = 1'b0;
    sent             = 0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_ROTATION_ANGLE;
    cfg_ch.data      = '0;
    model_ch.valid   = 1'b0;
    model_ch.model_x = '0;
    model_ch.model_y = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    send_corners();
    set_pose(16'h4000, 24'sh7FFFFF, 24'sh7FFFFF);
    send_corners();
    set_pose(16'hE000, 24'sh800000, 24'sh800000);
    send_corners();
    set_pose(16'hFFFF, pick_offset(), pick_offset());
    poke_spare();
    send_corners();

    while (sent < RANDOM_ITEMS) begin
      int n;
      steady = ($urandom_range(0, 3) == 0);
      set_pose(pick_angle(), pick_offset(), pick_offset());
      if ($urandom_range(0, 4) == 0) begin
        poke_spare();
      end
      n = $urandom_range(30, 90);
      repeat (n) send_vertex(pick_coord(), pick_coord());
      sent += n;
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
